// ===== sv/tds_median_compensated_ppm_unit_defines.svh =====
// assertion macros shared by the tds unit modules
`ifndef TDS_MEDIAN_COMPENSATED_PPM_UNIT_DEFINES_SVH
`define TDS_MEDIAN_COMPENSATED_PPM_UNIT_DEFINES_SVH

// checked only outside reset
`define TDSMC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define TDSMC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/tdsmc_pkg.sv =====
package tdsmc_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TEMP_W   = 10;
  localparam int unsigned PPM_W    = 14;
  localparam int unsigned MEDIAN_W = 12;

  // opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // 25 C in sixteenths of a degree
  localparam logic [TEMP_W-1:0] TEMP_RESET = 10'd400;

  // fixed point constants
  localparam logic [17:0] VREF_Q16  = 18'd216269;  // 3.3 in Q.16
  localparam logic [19:0] RECIP_25  = 20'd671089;  // ceil(2^24 / 25)
  localparam logic [19:0] COEF_A    = 20'd546488;  // 133.42 in Q.12
  localparam logic [19:0] COEF_B    = 20'd1048003; // 255.86 in Q.12
  localparam logic [21:0] COEF_C    = 22'd3511869; // 857.39 in Q.12
  localparam logic [PPM_W-1:0] PPM_MAX = 14'd16383;

  // shared multiplier widths
  localparam int unsigned MUL_A_W = 22;
  localparam int unsigned MUL_B_W = 28;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // one queued input word
  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
  } tdsmc_word_t;

endpackage

// ===== sv/tdsmc_front.sv =====
module tdsmc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tdsmc_pkg::tdsmc_word_t in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tdsmc_pkg::tdsmc_word_t out_word_o
);
  import tdsmc_pkg::*;

  localparam int unsigned DEPTH = 2;

  tdsmc_word_t q_q [DEPTH];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push;
  logic        pop;

  // handshake
  assign in_ready_o  = (cnt_q != 2'(DEPTH));
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = q_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= in_word_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== sv/tdsmc_window.sv =====
`include "tds_median_compensated_ppm_unit_defines.svh"

module tdsmc_window #(
  parameter int unsigned WINDOW   = 32,
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tdsmc_pkg::tdsmc_word_t in_word_i,
  output logic                  med_valid_o,
  input  logic                  med_ready_i,
  output logic [ADC_BITS-1:0]   med_o
);
  import tdsmc_pkg::*;

  localparam int unsigned AW    = $clog2(WINDOW);
  localparam int unsigned CW    = $clog2(WINDOW + 1);
  localparam int unsigned BW    = $clog2(ADC_BITS);
  localparam int unsigned EW    = (ADC_BITS > SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam bit          EVEN  = ((WINDOW % 2) == 0);
  localparam int unsigned K_LO  = EVEN ? (WINDOW / 2 - 1) : ((WINDOW - 1) / 2);
  localparam int unsigned K_HI  = WINDOW / 2;

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN, ST_SEND} state_e;

  state_e              state_q;
  logic [AW-1:0]       slot_q;
  logic [WINDOW-1:0]   vld_q;
  logic [AW-1:0]       addr_q;
  logic [ADC_BITS-1:0] mem [WINDOW];
  logic [ADC_BITS-1:0] rd_data_q;
  logic                rd_vld_q;
  logic                rd_live_q;
  logic [CW-1:0]       cnt_q;
  logic [CW-1:0]       rank_q;
  logic [ADC_BITS-1:0] prefix_q;
  logic [BW-1:0]       bit_q;
  logic                second_q;
  logic [ADC_BITS-1:0] low_q;
  logic [ADC_BITS-1:0] med_q;

  logic                accept;
  logic                we;
  logic [EW-1:0]       sample_ext;
  logic [ADC_BITS-1:0] wr_data;
  logic [AW-1:0]       slot_nxt;
  logic [ADC_BITS-1:0] entry;
  logic [ADC_BITS-1:0] hi_mask;
  logic                hit;
  logic [CW-1:0]       cnt_sum;
  logic                take_one;
  logic [ADC_BITS-1:0] prefix_new;
  logic [ADC_BITS:0]   pair_sum;

  // write side
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign we         = accept && (in_word_i.op == OP_SAMPLE);
  assign sample_ext = EW'(in_word_i.sample);
  assign wr_data    = sample_ext[ADC_BITS-1:0];
  assign slot_nxt   = (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;

  // radix select: count entries under the prefix with a zero at bit_q
  assign entry      = rd_vld_q ? rd_data_q : '0;
  assign hi_mask    = ({ADC_BITS{1'b1}} << bit_q) << 1;
  assign hit        = rd_live_q && (((entry ^ prefix_q) & hi_mask) == '0) && !entry[bit_q];
  assign cnt_sum    = cnt_q + CW'(hit);
  assign take_one   = (rank_q >= cnt_sum);
  assign prefix_new = prefix_q | (take_one ? (ADC_BITS'(1) << bit_q) : '0);
  assign pair_sum   = {1'b0, low_q} + {1'b0, prefix_new};

  assign med_valid_o = (state_q == ST_SEND);
  assign med_o       = med_q;

  // sample memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[slot_q] <= wr_data;
    end
    rd_data_q <= mem[addr_q];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      slot_q    <= '0;
      vld_q     <= '0;
      addr_q    <= '0;
      rd_vld_q  <= 1'b0;
      rd_live_q <= 1'b0;
      cnt_q     <= '0;
      rank_q    <= '0;
      prefix_q  <= '0;
      bit_q     <= '0;
      second_q  <= 1'b0;
      low_q     <= '0;
      med_q     <= '0;
    end else begin
      rd_vld_q <= vld_q[addr_q];
      case (state_q)
        ST_IDLE: begin
          rd_live_q <= 1'b0;
          if (we) begin
            vld_q[slot_q] <= 1'b1;
            slot_q        <= slot_nxt;
          end else if (accept) begin
            rank_q   <= CW'(K_LO);
            prefix_q <= '0;
            bit_q    <= BW'(ADC_BITS - 1);
            addr_q   <= '0;
            cnt_q    <= '0;
            second_q <= 1'b0;
            state_q  <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          rd_live_q <= 1'b1;
          cnt_q     <= cnt_sum;
          if (addr_q == AW'(WINDOW - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          rd_live_q <= 1'b0;
          prefix_q  <= prefix_new;
          if (take_one) begin
            rank_q <= rank_q - cnt_sum;
          end
          cnt_q  <= '0;
          addr_q <= '0;
          if (bit_q != '0) begin
            bit_q   <= bit_q - 1'b1;
            state_q <= ST_SWEEP;
          end else if (EVEN && !second_q) begin
            // lower middle found, now the upper one
            low_q    <= prefix_new;
            second_q <= 1'b1;
            rank_q   <= CW'(K_HI);
            prefix_q <= '0;
            bit_q    <= BW'(ADC_BITS - 1);
            state_q  <= ST_SWEEP;
          end else begin
            med_q   <= EVEN ? pair_sum[ADC_BITS:1] : prefix_new;
            state_q <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (med_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `TDSMC_ASSERT(a_cnt_bound, cnt_q <= CW'(WINDOW), "count exceeds window")
  `TDSMC_ASSERT(a_rank_bound, rank_q < CW'(WINDOW), "rank outside window")
  `TDSMC_ASSERT(a_slot_bound, slot_q <= AW'(WINDOW - 1), "write slot outside window")

endmodule

// ===== sv/tdsmc_calc.sv =====
`include "tds_median_compensated_ppm_unit_defines.svh"

module tdsmc_calc #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             med_valid_i,
  output logic                             med_ready_o,
  input  logic [ADC_BITS-1:0]              med_i,
  input  logic [tdsmc_pkg::TEMP_W-1:0]     temp_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tdsmc_pkg::PPM_W-1:0]      ppm_o,
  output logic [tdsmc_pkg::MEDIAN_W-1:0]   median_o,
  output logic                             sat_o
);
  import tdsmc_pkg::*;

  localparam int unsigned VW   = ADC_BITS + 6;
  localparam int unsigned DW   = VW + 12;
  localparam int unsigned CNTW = $clog2(DW + 1);
  localparam int unsigned KW   = 13;
  localparam int unsigned C_W  = 20;
  localparam int unsigned C2_W = 24;
  localparam int unsigned C3_W = 28;
  localparam int unsigned PW   = PROD_W - 29;
  localparam int unsigned MXW  = (ADC_BITS > MEDIAN_W) ? ADC_BITS : MEDIAN_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VOLT, ST_COEF, ST_DIV, ST_CLAMP, ST_SQ, ST_CUBE,
    ST_TERM_A, ST_TERM_C, ST_TERM_B, ST_OUT
  } state_e;

  state_e               state_q;
  logic [MUL_A_W-1:0]   mul_a_q;
  logic [MUL_B_W-1:0]   mul_b_q;
  logic [ADC_BITS-1:0]  med_q;
  logic [DW-1:0]        dvd_q;
  logic [KW-1:0]        k_q;
  logic [KW-1:0]        rem_q;
  logic [CNTW-1:0]      div_cnt_q;
  logic [C_W-1:0]       c_q;
  logic [C2_W-1:0]      c2_q;
  logic [PROD_W-1:0]    acc_q;
  logic [PPM_W-1:0]     ppm_q;
  logic                 sat_q;
  logic                 out_valid_q;
  logic [PPM_W-1:0]     out_ppm_q;
  logic [MEDIAN_W-1:0]  out_med_q;
  logic                 out_sat_q;

  logic [PROD_W-1:0]    prod;
  logic [KW:0]          rem_sh;
  logic                 ge;
  logic [KW-1:0]        rem_nx;
  logic [C_W-1:0]       c_clamp;
  logic [10:0]          tsum;
  logic [17:0]          tscaled;
  logic [PROD_W-1:0]    diff;
  logic [PW-1:0]        ppm_full;
  logic                 ppm_sat;
  logic [MXW-1:0]       med_ext;

  // shared multiplier, operands registered
  assign prod = PROD_W'(mul_a_q) * PROD_W'(mul_b_q);

  // restoring divider step
  assign rem_sh = {rem_q, dvd_q[DW-1]};
  assign ge     = (rem_sh >= {1'b0, k_q});
  assign rem_nx = ge ? KW'(rem_sh - {1'b0, k_q}) : rem_sh[KW-1:0];

  // quotients of 16 V and more saturate the cubic anyway
  assign c_clamp = (|dvd_q[DW-1:C_W]) ? '1 : dvd_q[C_W-1:0];

  // temperature coefficient numerator (T16 + 400) * 128
  assign tsum    = 11'(temp_i) + 11'd400;
  assign tscaled = {tsum, 7'b0};

  // final difference and clip
  assign diff     = acc_q - prod;
  assign ppm_full = (acc_q > prod) ? diff[PROD_W-1:29] : '0;
  assign ppm_sat  = (ppm_full > PW'(PPM_MAX));
  assign med_ext  = MXW'(med_q);

  assign med_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign ppm_o       = out_ppm_q;
  assign median_o    = out_med_q;
  assign sat_o       = out_sat_q;

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        med_q   <= med_i;
        mul_a_q <= MUL_A_W'(VREF_Q16);
        mul_b_q <= MUL_B_W'(med_i);
      end
      ST_VOLT: begin
        dvd_q   <= {prod[12 +: VW], 12'b0};
        mul_a_q <= MUL_A_W'(RECIP_25);
        mul_b_q <= MUL_B_W'(tscaled);
      end
      ST_COEF: begin
        k_q   <= prod[24 +: KW];
        rem_q <= '0;
      end
      ST_DIV: begin
        rem_q <= rem_nx;
        dvd_q <= {dvd_q[DW-2:0], ge};
      end
      ST_CLAMP: begin
        c_q     <= c_clamp;
        mul_a_q <= MUL_A_W'(c_clamp);
        mul_b_q <= MUL_B_W'(c_clamp);
      end
      ST_SQ: begin
        c2_q    <= prod[16 +: C2_W];
        mul_a_q <= MUL_A_W'(c_q);
        mul_b_q <= MUL_B_W'(prod[16 +: C2_W]);
      end
      ST_CUBE: begin
        mul_a_q <= MUL_A_W'(COEF_A);
        mul_b_q <= MUL_B_W'(prod[16 +: C3_W]);
      end
      ST_TERM_A: begin
        acc_q   <= prod;
        mul_a_q <= MUL_A_W'(COEF_C);
        mul_b_q <= MUL_B_W'(c_q);
      end
      ST_TERM_C: begin
        acc_q   <= acc_q + prod;
        mul_a_q <= MUL_A_W'(COEF_B);
        mul_b_q <= MUL_B_W'(c2_q);
      end
      ST_TERM_B: begin
        sat_q <= ppm_sat;
        ppm_q <= ppm_sat ? PPM_MAX : ppm_full[PPM_W-1:0];
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_ppm_q <= ppm_q;
          out_med_q <= med_ext[MEDIAN_W-1:0];
          out_sat_q <= sat_q;
        end
      end
      default: ;
    endcase
  end

  // sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE:   if (med_valid_i) state_q <= ST_VOLT;
        ST_VOLT:   state_q <= ST_COEF;
        ST_COEF: begin
          div_cnt_q <= CNTW'(DW);
          state_q   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == CNTW'(1)) begin
            state_q <= ST_CLAMP;
          end
        end
        ST_CLAMP:  state_q <= ST_SQ;
        ST_SQ:     state_q <= ST_CUBE;
        ST_CUBE:   state_q <= ST_TERM_A;
        ST_TERM_A: state_q <= ST_TERM_C;
        ST_TERM_C: state_q <= ST_TERM_B;
        ST_TERM_B: state_q <= ST_OUT;
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `TDSMC_ASSERT(a_valid_from_out, $rose(out_valid_q) |-> $past(state_q == ST_OUT), "result without finish")
  `TDSMC_ASSERT(a_sat_clip, out_valid_q && out_sat_q |-> out_ppm_q == PPM_MAX, "clip flag without max")
  `TDSMC_ASSERT(a_div_count, state_q == ST_DIV |-> div_cnt_q != '0, "divider count ran out")

endmodule

// ===== sv/tds_median_compensated_ppm_unit.sv =====
// TDS probe unit: median filter, temperature compensation, ppm conversion.
// Input stream s_axis: tuser[0] is the opcode (0 store sample, 1 report),
// tdata[11:0] the raw ADC sample. A sample is written into a ring window of
// WINDOW entries; a report returns one word on m_axis with the ppm value,
// the window median and a clip flag. Samples give no output word.
// cfg channel writes the water temperature in 1/16 C; write it only idle.
// Sample words are taken one per cycle through a two-word queue while the window is not busy with a report.
// A report sweeps the window once per median bit for each median pass (two passes
// for an even WINDOW, one for odd) over the single read port of the window
// memory, then runs the divider and the cubic on one shared multiplier.
// Reset empties the queue, zeroes the window and the write slot, and sets
// the temperature to 25 C. While m_axis is stalled the result is held,
// one more report finishes into the back end and the queue then fills and
// deasserts s_axis_tready.
module tds_median_compensated_ppm_unit #(
  parameter int unsigned WINDOW   = 32,
  parameter int unsigned ADC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // adc_sample[11:0], zero pad
  input  logic [0:0]  s_axis_tuser,   // opcode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // tds_ppm[13:0], median_code[25:14], zero pad
  output logic [0:0]  m_axis_tuser,   // saturated[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [tdsmc_pkg::TEMP_W-1:0] cfg_data_i
);
  import tdsmc_pkg::*;

  tdsmc_word_t         in_word;
  tdsmc_word_t         q_word;
  logic                q_valid;
  logic                q_ready;
  logic                med_valid;
  logic                med_ready;
  logic [ADC_BITS-1:0] med;
  logic [TEMP_W-1:0]   temp_q;
  logic [PPM_W-1:0]    ppm;
  logic [MEDIAN_W-1:0] median;
  logic                sat;

  // temperature register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= TEMP_RESET;
    end else if (cfg_valid_i) begin
      temp_q <= cfg_data_i;
    end
  end

  assign in_word.op     = s_axis_tuser[0];
  assign in_word.sample = s_axis_tdata[SAMPLE_W-1:0];

  // front queue
  tdsmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_word_i   (in_word),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_word_o  (q_word)
  );

  // window store and median select
  tdsmc_window #(
    .WINDOW   (WINDOW),
    .ADC_BITS (ADC_BITS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_word_i   (q_word),
    .med_valid_o (med_valid),
    .med_ready_i (med_ready),
    .med_o       (med)
  );

  // compensation and ppm
  tdsmc_calc #(
    .ADC_BITS (ADC_BITS)
  ) u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .med_valid_i (med_valid),
    .med_ready_o (med_ready),
    .med_i       (med),
    .temp_i      (temp_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ppm_o       (ppm),
    .median_o    (median),
    .sat_o       (sat)
  );

  assign m_axis_tdata = {6'b0, median, ppm};
  assign m_axis_tuser = sat;

endmodule
